// ----- hw/rtl/pced_pkg.sv -----
`default_nettype none
package pced_pkg;

   localparam int PINS_PER_PORT = 8;
   localparam int HISTORY_LEN   = 8;
   localparam int PIN_IDX_W     = (PINS_PER_PORT > 1) ? $clog2(PINS_PER_PORT) : 1;
   localparam logic [3:0] PIN_LIMIT = 4'(PINS_PER_PORT);

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] REG_INPUT_PINS       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DIGITAL_PINS     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_EDGE_MODES       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SLOPE_THRESHOLDS = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_STEP_INCREMENTS  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_PORT_NUMBER      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_ANALOG_CAPABLE   = 3'd6;

   localparam logic [1:0] EDGE_NONE    = 2'd0;
   localparam logic [1:0] EDGE_FALLING = 2'd1;
   localparam logic [1:0] EDGE_RISING  = 2'd2;
   localparam logic [1:0] EDGE_BOTH    = 2'd3;

   typedef struct packed {
      logic [7:0]  input_pins;
      logic [7:0]  digital_pins;
      logic [15:0] edge_modes;
      logic [63:0] slope_thresholds;
      logic [63:0] step_increments;
      logic [2:0]  port_number;
      logic        analog_capable;
   } cfg_type;

   typedef struct packed {
      logic [2:0] pin_index;
      logic       raw_level;
      logic [7:0] analog_sample;
      logic       scan_end;
   } item_type;

   typedef struct packed {
      logic       event_valid;
      logic [5:0] event_address;
      logic       filtered_level;
   } result_type;

endpackage
`default_nettype wire

// ----- hw/rtl/pin_change_event_detector.sv -----
// An accepted req passes through the input register and then the result register to rsp_valid.
// Throughput: one item per cycle while the rsp side is not stalled; the per-pin state update is one level of logic.
// A stalled rsp side holds one result while one more item waits in the input register.
// Reset (synchronous, active high) clears config, pin history, readings, slope flags,
// and sets the first-scan flag; both pipeline registers come up empty.
`default_nettype none
module pin_change_event_detector (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire [2:0]                        req_pin_index,
   input  wire                              req_raw_level,
   input  wire [7:0]                        req_analog_sample,
   input  wire                              req_scan_end,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic                             rsp_event_valid,
   output logic [5:0]                       rsp_event_address,
   output logic                             rsp_filtered_level,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire [pced_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire [pced_pkg::CSR_DATA_W-1:0]   csr_data
);
   import pced_pkg::*;

   cfg_type    cfg;
   item_type   item_ff;
   logic       s1_valid_ff;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       advance;

   pced_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pced_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) s1_valid_ff <= req_valid;
         if (advance) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
      if (req_valid && req_ready) begin
         item_ff.pin_index     <= req_pin_index;
         item_ff.raw_level     <= req_raw_level;
         item_ff.analog_sample <= req_analog_sample;
         item_ff.scan_end      <= req_scan_end;
      end
      if (advance) rsp_ff <= result;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_valid    = rsp_ff.event_valid;
   assign rsp_event_address  = rsp_ff.event_address;
   assign rsp_filtered_level = rsp_ff.filtered_level;

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   a_ready_only_when_room : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff && rsp_valid_ff && !rsp_ready)
      else $error("input stalled without a full pipeline");

   a_accept_loads : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> s1_valid_ff)
      else $error("accepted item lost from input register");

   a_advance_fills : assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("advanced item did not reach result register");

endmodule
`default_nettype wire

// ----- hw/rtl/pced_cfg.sv -----
`default_nettype none
module pced_cfg (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire [pced_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire [pced_pkg::CSR_DATA_W-1:0]   csr_data,
   output pced_pkg::cfg_type                cfg
);
   import pced_pkg::*;

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_INPUT_PINS:       cfg_ff.input_pins       <= csr_data[7:0];
            REG_DIGITAL_PINS:     cfg_ff.digital_pins     <= csr_data[7:0];
            REG_EDGE_MODES:       cfg_ff.edge_modes       <= csr_data[15:0];
            REG_SLOPE_THRESHOLDS: cfg_ff.slope_thresholds <= csr_data[63:0];
            REG_STEP_INCREMENTS:  cfg_ff.step_increments  <= csr_data[63:0];
            REG_PORT_NUMBER:      cfg_ff.port_number      <= csr_data[2:0];
            REG_ANALOG_CAPABLE:   cfg_ff.analog_capable   <= csr_data[0];
            default: ;
         endcase
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/pced_core.sv -----
`default_nettype none
module pced_core (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    fire,
   input  pced_pkg::item_type     item,
   input  pced_pkg::cfg_type      cfg,
   output pced_pkg::result_type   result
);
   import pced_pkg::*;

   logic [HISTORY_LEN-1:0] hist_ff [PINS_PER_PORT];
   logic [7:0]             acc_ff  [PINS_PER_PORT];
   logic [PINS_PER_PORT-1:0] prev_ff;
   logic [PINS_PER_PORT-1:0] fall_ff;
   logic                     first_ff;

   logic [HISTORY_LEN-1:0]   hist_new;
   logic [PINS_PER_PORT-1:0] prev_in;
   logic [PINS_PER_PORT-1:0] fall_in;
   logic                     first_in;
   logic                     hist_we;
   logic                     acc_we;
   logic                     pin_ok;
   logic [PIN_IDX_W-1:0]     idx;
   logic                     is_input;
   logic                     is_digital;
   logic                     prev;
   logic [1:0]               mode;
   logic [7:0]               thr;
   logic [7:0]               inc;
   logic [7:0]               last;
   logic [7:0]               diff;
   logic                     fall;
   logic                     level;
   logic                     change;

   always_comb begin
      pin_ok     = {1'b0, item.pin_index} < PIN_LIMIT;
      idx        = item.pin_index[PIN_IDX_W-1:0];
      is_input   = cfg.input_pins[item.pin_index];
      is_digital = cfg.digital_pins[item.pin_index];
      prev       = prev_ff[idx];
      mode       = cfg.edge_modes[{item.pin_index, 1'b0} +: 2];
      thr        = cfg.slope_thresholds[{item.pin_index, 3'b000} +: 8];
      inc        = cfg.step_increments[{item.pin_index, 3'b000} +: 8];
      last       = acc_ff[idx];
      fall       = fall_ff[idx];
      hist_new   = {hist_ff[idx][HISTORY_LEN-2:0], item.raw_level};
      diff       = (item.analog_sample > last) ? (item.analog_sample - last)
                                               : (last - item.analog_sample);
      level      = item.raw_level;
      change     = 1'b0;
      hist_we    = 1'b0;
      acc_we     = 1'b0;
      prev_in    = prev_ff;
      fall_in    = fall_ff;
      if (pin_ok) begin
         if (is_input && is_digital) begin
            if (mode != EDGE_NONE) begin
               hist_we = 1'b1;
               level   = &hist_new;
               case (mode)
                  EDGE_FALLING: change = prev && !level;
                  EDGE_RISING:  change = !prev && level;
                  EDGE_BOTH:    change = prev != level;
                  default:      change = 1'b0;
               endcase
            end
         end else if (is_input && cfg.analog_capable) begin
            if (item.analog_sample > last) begin
               change = fall ? (diff > thr) : (diff > inc);
               if (fall && change) fall_in[idx] = 1'b0;
            end else if (item.analog_sample < last) begin
               change = fall ? (diff > inc) : (diff > thr);
               if (!fall && change) fall_in[idx] = 1'b1;
            end
            acc_we = first_ff || change;
         end
         prev_in[idx] = level;
      end
      first_in = item.scan_end ? 1'b0 : first_ff;
      result.event_valid    = !first_ff && change;
      result.event_address  = {cfg.port_number, item.pin_index};
      result.filtered_level = level;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PINS_PER_PORT; i++) begin
            hist_ff[i] <= '0;
            acc_ff[i]  <= '0;
         end
         prev_ff  <= '0;
         fall_ff  <= '0;
         first_ff <= 1'b1;
      end else if (fire) begin
         if (hist_we) hist_ff[idx] <= hist_new;
         if (acc_we)  acc_ff[idx]  <= item.analog_sample;
         prev_ff  <= prev_in;
         fall_ff  <= fall_in;
         first_ff <= first_in;
      end
   end

endmodule
`default_nettype wire
